/* rtl/gmt_pkg.sv */
package gmt_pkg;

   localparam int MEMBER_W = 8;
   localparam int GROUP_W = 4;
   localparam int SLOT_W = 4;
   localparam int MODE_W = 3;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W = $clog2(MAX_RESULTS);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD           = 3'd0,
      MODE_REMOVE        = 3'd1,
      MODE_LOOKUP_MEMBER = 3'd2,
      MODE_LOOKUP_SLOT   = 3'd3,
      MODE_LIST          = 3'd4
   } gmt_mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_RM_OCC,
      ST_RM_RD,
      ST_RM_MV,
      ST_RM_RN,
      ST_LS_OCC,
      ST_LS_RD,
      ST_LS_EM,
      ST_EMIT
   } gmt_state_type;

   typedef struct packed {
      logic                found;
      logic [GROUP_W-1:0]  out_group;
      logic [SLOT_W-1:0]   out_slot;
      logic [MEMBER_W-1:0] out_member;
      logic                last;
   } gmt_rsp_type;

   localparam gmt_rsp_type RSP_MISS = '{
      found: 1'b0, out_group: '0, out_slot: '0, out_member: '0, last: 1'b1
   };

endpackage

/* rtl/gmt_if.sv */
interface gmt_req_if import gmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [MEMBER_W-1:0] member_id;
   logic [GROUP_W-1:0]  group_id;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output mode, output member_id, output group_id,
                   output slot, input ready);
   modport sink (input valid, input mode, input member_id, input group_id,
                 input slot, output ready);
endinterface

interface gmt_rsp_if import gmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [GROUP_W-1:0]  out_group;
   logic [SLOT_W-1:0]   out_slot;
   logic [MEMBER_W-1:0] out_member;
   logic                last;

   modport source (output valid, output found, output out_group, output out_slot,
                   output out_member, output last, input ready);
   modport sink (input valid, input found, input out_group, input out_slot,
                 input out_member, input last, output ready);
endinterface

/* rtl/gmt_ram.sv */
module gmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= ram_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/gmt_ctrl.sv */
module gmt_ctrl import gmt_pkg::*; #(
   parameter int NUM_MEMBERS = 256,
   parameter int NUM_GROUPS = 16,
   parameter int GROUP_SLOTS = 16,
   localparam int MW = $clog2(NUM_MEMBERS),
   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1,
   localparam int SW = $clog2(GROUP_SLOTS),
   localparam int SAW = $clog2(NUM_GROUPS * GROUP_SLOTS),
   localparam int MWORD = 1 + GW + SW
) (
   input  logic                   clock,
   input  logic                   reset,
   gmt_req_if.sink                req,
   gmt_rsp_if.source              rsp,
   output logic                   mm_we,
   output logic [MW-1:0]          mm_waddr,
   output logic [MWORD-1:0]       mm_wdata,
   output logic                   mm_re,
   output logic [MW-1:0]          mm_raddr,
   input  logic [MWORD-1:0]       mm_rdata,
   output logic                   sm_we,
   output logic [SAW-1:0]         sm_waddr,
   output logic [MEMBER_W-1:0]    sm_wdata,
   output logic                   sm_re,
   output logic [SAW-1:0]         sm_raddr,
   input  logic [MEMBER_W-1:0]    sm_rdata,
   output logic                   om_we,
   output logic [GW-1:0]          om_waddr,
   output logic [GROUP_SLOTS-1:0] om_wdata,
   output logic                   om_re,
   output logic [GW-1:0]          om_raddr,
   input  logic [GROUP_SLOTS-1:0] om_rdata
);

   localparam int CLR_N = (NUM_MEMBERS > NUM_GROUPS) ? NUM_MEMBERS : NUM_GROUPS;
   localparam int CW = $clog2(CLR_N);

   gmt_state_type          state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [MEMBER_W-1:0]    mem_ff, mem_in;
   logic [GROUP_W-1:0]     grp_ff, grp_in;
   logic [SLOT_W-1:0]      slt_ff, slt_in;
   logic [GW-1:0]          wgrp_ff, wgrp_in;
   logic [SW-1:0]          pos_ff, pos_in;
   logic [SW-1:0]          idx_ff, idx_in;
   logic [SW-1:0]          top_ff, top_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [GROUP_SLOTS-1:0] occ_ff, occ_in;
   logic [MEMBER_W-1:0]    x_ff, x_in;
   gmt_rsp_type            res_ff, res_in;
   gmt_rsp_type            out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CW-1:0]          clr_ff, clr_in;

   logic                   m_ok, g_ok, s_ok, out_free, last_hit;
   logic [MW-1:0]          m_idx;
   logic [GW-1:0]          g_idx;
   logic [SW-1:0]          s_idx, idx_nx, top_calc;
   logic                   mrd_valid;
   logic [GW-1:0]          mrd_grp;
   logic [SW-1:0]          mrd_slot;
   logic [GROUP_SLOTS-1:0] occ_down, occ_shift;

   function automatic logic [SAW-1:0] slot_addr(input logic [GW-1:0] g,
                                                input logic [SW-1:0] s);
      return SAW'(g) * SAW'(GROUP_SLOTS) + SAW'(s);
   endfunction

   assign m_ok = 32'(mem_ff) < 32'(NUM_MEMBERS);
   assign g_ok = 32'(grp_ff) < 32'(NUM_GROUPS);
   assign s_ok = 32'(slt_ff) < 32'(GROUP_SLOTS);
   assign m_idx = MW'(mem_ff);
   assign g_idx = GW'(grp_ff);
   assign s_idx = SW'(slt_ff);
   assign idx_nx = SW'(idx_ff + 1'b1);
   assign out_free = !out_valid_ff || rsp.ready;
   assign last_hit = (idx_ff == top_ff) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));

   assign mrd_valid = mm_rdata[MWORD-1];
   assign mrd_grp = mm_rdata[SW +: GW];
   assign mrd_slot = mm_rdata[SW-1:0];

   // highest occupied slot of the word just read
   always_comb begin
      top_calc = '0;
      for (int j = 0; j < GROUP_SLOTS; j++) begin
         if (om_rdata[j]) begin
            top_calc = SW'(j);
         end
      end
   end

   // occupancy after a remove: slots pos..top-1 take the bit above, top is freed
   assign occ_down = om_rdata >> 1;
   always_comb begin
      occ_shift = om_rdata;
      for (int j = 0; j < GROUP_SLOTS; j++) begin
         if (j == int'(top_calc)) begin
            occ_shift[j] = 1'b0;
         end else if (j >= int'(pos_ff) && j < int'(top_calc)) begin
            occ_shift[j] = occ_down[j];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      mem_in = mem_ff;
      grp_in = grp_ff;
      slt_in = slt_ff;
      wgrp_in = wgrp_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      top_in = top_ff;
      cnt_in = cnt_ff;
      occ_in = occ_ff;
      x_in = x_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      clr_in = clr_ff;
      req.ready = 1'b0;
      mm_we = 1'b0;
      mm_waddr = '0;
      mm_wdata = '0;
      mm_re = 1'b0;
      mm_raddr = '0;
      sm_we = 1'b0;
      sm_waddr = '0;
      sm_wdata = '0;
      sm_re = 1'b0;
      sm_raddr = '0;
      om_we = 1'b0;
      om_waddr = '0;
      om_wdata = '0;
      om_re = 1'b0;
      om_raddr = '0;

      case (state_ff)
         ST_CLEAR: begin
            mm_we = 32'(clr_ff) < 32'(NUM_MEMBERS);
            mm_waddr = MW'(clr_ff);
            om_we = 32'(clr_ff) < 32'(NUM_GROUPS);
            om_waddr = GW'(clr_ff);
            clr_in = CW'(clr_ff + 1'b1);
            if (clr_ff == CW'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               mode_in = req.mode;
               mem_in = req.member_id;
               grp_in = req.group_id;
               slt_in = req.slot;
               case (req.mode)
                  MODE_ADD, MODE_REMOVE, MODE_LOOKUP_MEMBER, MODE_LOOKUP_SLOT,
                  MODE_LIST: state_in = ST_FETCH;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            case (mode_ff)
               MODE_ADD: begin
                  if (m_ok && g_ok && s_ok) begin
                     om_re = 1'b1;
                     om_raddr = g_idx;
                     state_in = ST_DECODE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               MODE_REMOVE, MODE_LOOKUP_MEMBER, MODE_LIST: begin
                  if (m_ok) begin
                     mm_re = 1'b1;
                     mm_raddr = m_idx;
                     state_in = ST_DECODE;
                  end else if (mode_ff == MODE_REMOVE) begin
                     state_in = ST_IDLE;
                  end else begin
                     res_in = RSP_MISS;
                     state_in = ST_EMIT;
                  end
               end
               MODE_LOOKUP_SLOT: begin
                  if (g_ok && s_ok) begin
                     om_re = 1'b1;
                     om_raddr = g_idx;
                     sm_re = 1'b1;
                     sm_raddr = slot_addr(g_idx, s_idx);
                     state_in = ST_DECODE;
                  end else begin
                     res_in = '{found: 1'b0, out_group: grp_ff, out_slot: slt_ff,
                                out_member: '0, last: 1'b1};
                     state_in = ST_EMIT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DECODE: begin
            case (mode_ff)
               MODE_ADD: begin
                  sm_we = 1'b1;
                  sm_waddr = slot_addr(g_idx, s_idx);
                  sm_wdata = mem_ff;
                  mm_we = 1'b1;
                  mm_waddr = m_idx;
                  mm_wdata = {1'b1, g_idx, s_idx};
                  om_we = 1'b1;
                  om_waddr = g_idx;
                  om_wdata = om_rdata | (GROUP_SLOTS'(1) << s_idx);
                  state_in = ST_IDLE;
               end
               MODE_REMOVE: begin
                  if (mrd_valid) begin
                     mm_we = 1'b1;
                     mm_waddr = m_idx;
                     mm_wdata = '0;
                     wgrp_in = mrd_grp;
                     pos_in = mrd_slot;
                     om_re = 1'b1;
                     om_raddr = mrd_grp;
                     state_in = ST_RM_OCC;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               MODE_LOOKUP_MEMBER: begin
                  if (mrd_valid) begin
                     res_in = '{found: 1'b1, out_group: GROUP_W'(mrd_grp),
                                out_slot: SLOT_W'(mrd_slot), out_member: mem_ff,
                                last: 1'b1};
                  end else begin
                     res_in = RSP_MISS;
                  end
                  state_in = ST_EMIT;
               end
               MODE_LOOKUP_SLOT: begin
                  res_in = '{found: om_rdata[s_idx], out_group: grp_ff,
                             out_slot: slt_ff,
                             out_member: om_rdata[s_idx] ? sm_rdata : '0,
                             last: 1'b1};
                  state_in = ST_EMIT;
               end
               MODE_LIST: begin
                  if (mrd_valid) begin
                     wgrp_in = mrd_grp;
                     om_re = 1'b1;
                     om_raddr = mrd_grp;
                     state_in = ST_LS_OCC;
                  end else begin
                     res_in = RSP_MISS;
                     state_in = ST_EMIT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RM_OCC: begin
            occ_in = om_rdata;
            top_in = top_calc;
            idx_in = pos_ff;
            if (om_rdata == '0) begin
               state_in = ST_IDLE;
            end else begin
               om_we = 1'b1;
               om_waddr = wgrp_ff;
               om_wdata = occ_shift;
               state_in = (pos_ff < top_calc) ? ST_RM_RD : ST_IDLE;
            end
         end
         ST_RM_RD: begin
            sm_re = 1'b1;
            sm_raddr = slot_addr(wgrp_ff, idx_nx);
            state_in = ST_RM_MV;
         end
         ST_RM_MV: begin
            sm_we = 1'b1;
            sm_waddr = slot_addr(wgrp_ff, idx_ff);
            sm_wdata = sm_rdata;
            x_in = sm_rdata;
            if (occ_ff[idx_nx] && 32'(sm_rdata) < 32'(NUM_MEMBERS)) begin
               mm_re = 1'b1;
               mm_raddr = MW'(sm_rdata);
               state_in = ST_RM_RN;
            end else begin
               idx_in = idx_nx;
               state_in = (idx_nx < top_ff) ? ST_RM_RD : ST_IDLE;
            end
         end
         ST_RM_RN: begin
            // renumber only members that still belong to this group
            if (mrd_valid && mrd_grp == wgrp_ff) begin
               mm_we = 1'b1;
               mm_waddr = MW'(x_ff);
               mm_wdata = {1'b1, mrd_grp, idx_ff};
            end
            idx_in = idx_nx;
            state_in = (idx_nx < top_ff) ? ST_RM_RD : ST_IDLE;
         end
         ST_LS_OCC: begin
            occ_in = om_rdata;
            top_in = top_calc;
            idx_in = '0;
            cnt_in = '0;
            if (om_rdata == '0) begin
               res_in = RSP_MISS;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_LS_RD;
            end
         end
         ST_LS_RD: begin
            if (!occ_ff[idx_ff]) begin
               idx_in = idx_nx;
            end else if (out_free) begin
               sm_re = 1'b1;
               sm_raddr = slot_addr(wgrp_ff, idx_ff);
               state_in = ST_LS_EM;
            end
         end
         ST_LS_EM: begin
            out_in = '{found: 1'b1, out_group: GROUP_W'(wgrp_ff),
                       out_slot: SLOT_W'(idx_ff), out_member: sm_rdata,
                       last: last_hit};
            out_valid_in = 1'b1;
            if (last_hit) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_nx;
               cnt_in = CNT_W'(cnt_ff + 1'b1);
               state_in = ST_LS_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         out_valid_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      mem_ff <= mem_in;
      grp_ff <= grp_in;
      slt_ff <= slt_in;
      wgrp_ff <= wgrp_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      top_ff <= top_in;
      cnt_ff <= cnt_in;
      occ_ff <= occ_in;
      x_ff <= x_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.found = out_ff.found;
   assign rsp.out_group = out_ff.out_group;
   assign rsp.out_slot = out_ff.out_slot;
   assign rsp.out_member = out_ff.out_member;
   assign rsp.last = out_ff.last;

endmodule

/* rtl/group_membership_table.sv */
// lookup: fetch, decode, then emit offers the registered result once the output is free
// remove: clears the member entry, then moves each slot above it down and renumbers
// each moved occupied entry; list: scans the slots in order, skips empty ones and emits
// each occupied one once the output is free; one transaction at a time, the next is
// taken once the sequencer is back to idle
// after reset a clearing pass of max(NUM_MEMBERS, NUM_GROUPS) words holds req ready low
module group_membership_table import gmt_pkg::*; #(
   parameter int NUM_MEMBERS = 256,
   parameter int NUM_GROUPS = 16,
   parameter int GROUP_SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   gmt_req_if.sink   req_bus,
   gmt_rsp_if.source rsp_bus
);

   localparam int MW = $clog2(NUM_MEMBERS);
   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int SW = $clog2(GROUP_SLOTS);
   localparam int SAW = $clog2(NUM_GROUPS * GROUP_SLOTS);
   localparam int MWORD = 1 + GW + SW;

   logic                   mm_we, mm_re;
   logic [MW-1:0]          mm_waddr, mm_raddr;
   logic [MWORD-1:0]       mm_wdata, mm_rdata;
   logic                   sm_we, sm_re;
   logic [SAW-1:0]         sm_waddr, sm_raddr;
   logic [MEMBER_W-1:0]    sm_wdata, sm_rdata;
   logic                   om_we, om_re;
   logic [GW-1:0]          om_waddr, om_raddr;
   logic [GROUP_SLOTS-1:0] om_wdata, om_rdata;

   // per member: valid, group, slot
   gmt_ram #(.WIDTH(MWORD), .DEPTH(NUM_MEMBERS)) u_member_ram (
      .clock(clock), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
      .re(mm_re), .raddr(mm_raddr), .rdata(mm_rdata)
   );

   // per group and slot: member id
   gmt_ram #(.WIDTH(MEMBER_W), .DEPTH(NUM_GROUPS * GROUP_SLOTS)) u_slot_ram (
      .clock(clock), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
      .re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata)
   );

   // per group: occupancy bit per slot
   gmt_ram #(.WIDTH(GROUP_SLOTS), .DEPTH(NUM_GROUPS)) u_occ_ram (
      .clock(clock), .we(om_we), .waddr(om_waddr), .wdata(om_wdata),
      .re(om_re), .raddr(om_raddr), .rdata(om_rdata)
   );

   gmt_ctrl #(
      .NUM_MEMBERS(NUM_MEMBERS), .NUM_GROUPS(NUM_GROUPS), .GROUP_SLOTS(GROUP_SLOTS)
   ) u_ctrl (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .mm_we(mm_we), .mm_waddr(mm_waddr), .mm_wdata(mm_wdata),
      .mm_re(mm_re), .mm_raddr(mm_raddr), .mm_rdata(mm_rdata),
      .sm_we(sm_we), .sm_waddr(sm_waddr), .sm_wdata(sm_wdata),
      .sm_re(sm_re), .sm_raddr(sm_raddr), .sm_rdata(sm_rdata),
      .om_we(om_we), .om_waddr(om_waddr), .om_wdata(om_wdata),
      .om_re(om_re), .om_raddr(om_raddr), .om_rdata(om_rdata)
   );

endmodule

/* rtl/gmt_checker.sv */
module gmt_checker import gmt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_found,
   input logic [GROUP_W-1:0]  rsp_out_group,
   input logic [SLOT_W-1:0]   rsp_out_slot,
   input logic [MEMBER_W-1:0] rsp_out_member,
   input logic                rsp_last
);

   // clearing pass starts right after reset, nothing pending on the output
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({rsp_found, rsp_out_group, rsp_out_slot, rsp_out_member, rsp_last}))
      else $error("result payload changed while stalled");

   // a miss is always a single closing result with no member
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_out_member == '0)
      else $error("miss result not last or carries a member");

endmodule

bind group_membership_table gmt_checker u_gmt_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_found(rsp_bus.found),
   .rsp_out_group(rsp_bus.out_group),
   .rsp_out_slot(rsp_bus.out_slot),
   .rsp_out_member(rsp_bus.out_member),
   .rsp_last(rsp_bus.last)
);

/* dv/group_membership_table_tb.sv */
`timescale 1ns / 1ps

module group_membership_table_tb;
   import gmt_pkg::*;

   localparam int NUM_MEMBERS = 256;
   localparam int NUM_GROUPS = 16;
   localparam int GROUP_SLOTS = 16;
   localparam int RANDOM_OPS = 163;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   logic clock;
   logic reset;

   gmt_req_if req_bus ();
   gmt_rsp_if rsp_bus ();

   group_membership_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the membership tables
   bit                  mbr_known [NUM_MEMBERS];
   logic [GROUP_W-1:0]  mbr_group [NUM_MEMBERS];
   logic [SLOT_W-1:0]   mbr_slot [NUM_MEMBERS];
   logic [MEMBER_W-1:0] slot_owner [NUM_GROUPS][GROUP_SLOTS];
   logic [GROUP_SLOTS-1:0] slot_used [NUM_GROUPS];
   // slots 0..n-1 of a group have been written at least once
   int                  written_depth [NUM_GROUPS];

   gmt_rsp_type pending_replies [$];
   int          fail_count = 0;
   int          burst_left = 0;
   bit          hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic gmt_rsp_type make_reply(input logic found, input logic [GROUP_W-1:0] grp,
                                              input logic [SLOT_W-1:0] slt,
                                              input logic [MEMBER_W-1:0] mbr,
                                              input logic last);
      gmt_rsp_type r;
      r.found = found;
      r.out_group = grp;
      r.out_slot = slt;
      r.out_member = mbr;
      r.last = last;
      return r;
   endfunction

   function automatic void drop_member(input logic [MEMBER_W-1:0] m);
      logic [GROUP_W-1:0]     g;
      int                     pos;
      int                     top;
      int                     i;
      logic [GROUP_SLOTS-1:0] occ;
      logic [MEMBER_W-1:0]    moved;
      g = mbr_group[m];
      pos = mbr_slot[m];
      mbr_known[m] = 1'b0;
      occ = slot_used[g];
      if (occ == '0) return;
      top = 0;
      for (i = 0; i < GROUP_SLOTS; i++)
         if (occ[i]) top = i;
      // compaction: occupancy bits travel with the entries, gaps included
      for (i = pos; i < top; i++) begin
         slot_owner[g][i] = slot_owner[g][i+1];
         if (occ[i+1]) begin
            moved = slot_owner[g][i];
            occ[i] = 1'b1;
            if (mbr_known[moved] && mbr_group[moved] == g) mbr_slot[moved] = SLOT_W'(i);
         end else begin
            occ[i] = 1'b0;
         end
      end
      occ[top] = 1'b0;
      slot_used[g] = occ;
   endfunction

   function automatic void membership_step(input logic [MODE_W-1:0] op,
                                           input logic [MEMBER_W-1:0] m,
                                           input logic [GROUP_W-1:0] g,
                                           input logic [SLOT_W-1:0] s);
      int i;
      int count;
      logic [GROUP_W-1:0] mg;
      mg = mbr_group[m];
      case (op)
         MODE_ADD: begin
            slot_owner[g][s] = m;
            mbr_slot[m] = s;
            mbr_group[m] = g;
            mbr_known[m] = 1'b1;
            slot_used[g][s] = 1'b1;
            if (int'(s) == written_depth[g]) written_depth[g]++;
         end
         MODE_REMOVE: begin
            if (mbr_known[m]) drop_member(m);
         end
         MODE_LOOKUP_MEMBER: begin
            if (mbr_known[m]) pending_replies.push_back(make_reply(1'b1, mg, mbr_slot[m], m, 1'b1));
            else pending_replies.push_back(RSP_MISS);
         end
         MODE_LOOKUP_SLOT: begin
            if (slot_used[g][s])
               pending_replies.push_back(make_reply(1'b1, g, s, slot_owner[g][s], 1'b1));
            else
               pending_replies.push_back(make_reply(1'b0, g, s, '0, 1'b1));
         end
         MODE_LIST: begin
            count = 0;
            if (mbr_known[m]) begin
               for (i = 0; i < GROUP_SLOTS; i++) begin
                  if (slot_used[mg][i]) begin
                     pending_replies.push_back(make_reply(1'b1, mg, SLOT_W'(i),
                                                          slot_owner[mg][i], 1'b0));
                     count++;
                  end
               end
            end
            if (count == 0) pending_replies.push_back(RSP_MISS);
            else pending_replies[pending_replies.size()-1].last = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   // sender: bursts of back-to-back transactions separated by random gaps
   task automatic offer_request(input logic [MODE_W-1:0] op, input logic [MEMBER_W-1:0] m,
                                input logic [GROUP_W-1:0] g, input logic [SLOT_W-1:0] s);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid = 1'b1;
      req_bus.mode = op;
      req_bus.member_id = m;
      req_bus.group_id = g;
      req_bus.slot = s;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      membership_step(op, m, g, s);
      burst_left--;
   endtask

   function automatic logic [MEMBER_W-1:0] pick_member();
      if ($urandom_range(0, 99) < 85) return MEMBER_W'($urandom_range(0, 23));
      return MEMBER_W'($urandom_range(0, NUM_MEMBERS - 1));
   endfunction

   function automatic logic [GROUP_W-1:0] pick_group();
      if ($urandom_range(0, 99) < 85) return GROUP_W'($urandom_range(0, 3));
      return GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
   endfunction

   function automatic logic [SLOT_W-1:0] lowest_free_slot(input logic [GROUP_W-1:0] g);
      int i;
      for (i = 0; i < GROUP_SLOTS; i++)
         if (!slot_used[g][i]) return SLOT_W'(i);
      return SLOT_W'($urandom_range(0, GROUP_SLOTS - 1));
   endfunction

   task automatic test_empty_table();
      offer_request(MODE_LOOKUP_MEMBER, 8'd255, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_SLOT, 8'd0, 4'd15, 4'd15);
      offer_request(MODE_LIST, 8'd0, 4'd0, 4'd0);
      offer_request(MODE_REMOVE, 8'd0, 4'd0, 4'd0);
      offer_request(MODE_SPARE_LO, 8'd0, 4'd0, 4'd0);
      offer_request(MODE_SPARE_HI, 8'd255, 4'd15, 4'd15);
   endtask

   task automatic test_add_lookup();
      offer_request(MODE_ADD, 8'd255, 4'd15, 4'd15);
      offer_request(MODE_ADD, 8'd0, 4'd0, 4'd0);
      offer_request(MODE_ADD, 8'd1, 4'd0, 4'd1);
      offer_request(MODE_LOOKUP_MEMBER, 8'd255, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_SLOT, 8'd0, 4'd0, 4'd1);
      offer_request(MODE_LIST, 8'd0, 4'd0, 4'd0);
   endtask

   // old slot keeps naming the member after it moves elsewhere
   task automatic test_readd();
      offer_request(MODE_ADD, 8'd1, 4'd2, 4'd0);
      offer_request(MODE_LOOKUP_MEMBER, 8'd1, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_SLOT, 8'd0, 4'd0, 4'd1);
   endtask

   task automatic test_remove_corners();
      // member still known while its group is already empty
      offer_request(MODE_ADD, 8'd2, 4'd3, 4'd0);
      offer_request(MODE_ADD, 8'd3, 4'd3, 4'd0);
      offer_request(MODE_REMOVE, 8'd3, 4'd0, 4'd0);
      offer_request(MODE_LIST, 8'd2, 4'd0, 4'd0);
      offer_request(MODE_REMOVE, 8'd2, 4'd0, 4'd0);
      // member slot above the highest occupied slot
      offer_request(MODE_ADD, 8'd20, 4'd4, 4'd2);
      offer_request(MODE_ADD, 8'd21, 4'd4, 4'd5);
      offer_request(MODE_ADD, 8'd22, 4'd4, 4'd5);
      offer_request(MODE_REMOVE, 8'd22, 4'd0, 4'd0);
      offer_request(MODE_REMOVE, 8'd21, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_SLOT, 8'd0, 4'd4, 4'd2);
   endtask

   task automatic test_gap_shift();
      int k;
      for (k = 0; k < 4; k++)
         offer_request(MODE_ADD, MEMBER_W'(30 + k), 4'd5, SLOT_W'(k));
      offer_request(MODE_REMOVE, 8'd33, 4'd0, 4'd0);
      offer_request(MODE_ADD, 8'd34, 4'd5, 4'd4);
      offer_request(MODE_REMOVE, 8'd30, 4'd0, 4'd0);
      offer_request(MODE_LIST, 8'd31, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_MEMBER, 8'd34, 4'd0, 4'd0);
   endtask

   task automatic test_full_group();
      int k;
      for (k = 0; k < GROUP_SLOTS; k++)
         offer_request(MODE_ADD, MEMBER_W'(100 + k), 4'd7, SLOT_W'(k));
      offer_request(MODE_LIST, 8'd100, 4'd0, 4'd0);
      offer_request(MODE_REMOVE, 8'd107, 4'd0, 4'd0);
      offer_request(MODE_LIST, 8'd115, 4'd0, 4'd0);
      offer_request(MODE_LOOKUP_MEMBER, 8'd115, 4'd0, 4'd0);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      int k;
      hold_request = 1'b1;
      for (k = 0; k < 12; k++) begin
         if (k % 3 == 0) offer_request(MODE_LIST, 8'd101, 4'd0, 4'd0);
         else offer_request(MODE_LOOKUP_SLOT, 8'd0, 4'd7, SLOT_W'(k));
      end
   endtask

   task automatic test_random_ops();
      int k;
      int r;
      int cap;
      logic [GROUP_W-1:0] g;
      logic [SLOT_W-1:0]  s;
      for (k = 0; k < RANDOM_OPS; k++) begin
         r = $urandom_range(0, 99);
         g = pick_group();
         if (r < 40) begin
            // adds stay within the written part of a group so that compaction
            // only ever moves entries that hold a member
            cap = (written_depth[g] > GROUP_SLOTS - 1) ? GROUP_SLOTS - 1 : written_depth[g];
            if ((slot_used[g] >> written_depth[g]) != '0) begin
               offer_request(MODE_LOOKUP_SLOT, pick_member(), g, SLOT_W'($urandom_range(0, 15)));
            end else begin
               if ($urandom_range(0, 3) != 0) s = lowest_free_slot(g);
               else s = SLOT_W'($urandom_range(0, cap));
               offer_request(MODE_ADD, pick_member(), g, s);
            end
         end else if (r < 55) begin
            offer_request(MODE_REMOVE, pick_member(), g, SLOT_W'($urandom_range(0, 15)));
         end else if (r < 70) begin
            offer_request(MODE_LOOKUP_MEMBER, pick_member(), g, SLOT_W'($urandom_range(0, 15)));
         end else if (r < 82) begin
            offer_request(MODE_LOOKUP_SLOT, pick_member(), g, SLOT_W'($urandom_range(0, 15)));
         end else if (r < 95) begin
            offer_request(MODE_LIST, pick_member(), g, SLOT_W'($urandom_range(0, 15)));
         end else begin
            offer_request(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), pick_member(),
                          g, SLOT_W'($urandom_range(0, 15)));
         end
      end
   endtask

   // receiver stall pattern: segments of no stall, light stall and heavy stall
   initial begin
      int hold_left;
      int stall_left;
      int stall_style;
      hold_left = 0;
      stall_left = 0;
      stall_style = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            if (stall_left == 0) begin
               stall_style = $urandom_range(0, 2);
               stall_left = $urandom_range(10, 60);
            end
            stall_left--;
            case (stall_style)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready = ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      gmt_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected result transaction: found=%0d group=%0d slot=%0d member=%0d",
                   rsp_bus.found, rsp_bus.out_group, rsp_bus.out_slot, rsp_bus.out_member);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_bus.found);
               fail_count++;
            end
            if (rsp_bus.out_group !== want.out_group) begin
               $error("out_group: expected %0d, actual %0d", want.out_group, rsp_bus.out_group);
               fail_count++;
            end
            if (rsp_bus.out_slot !== want.out_slot) begin
               $error("out_slot: expected %0d, actual %0d", want.out_slot, rsp_bus.out_slot);
               fail_count++;
            end
            if (rsp_bus.out_member !== want.out_member) begin
               $error("out_member: expected %0d, actual %0d", want.out_member,
                      rsp_bus.out_member);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int i;
      int j;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_ADD;
      req_bus.member_id = '0;
      req_bus.group_id = '0;
      req_bus.slot = '0;
      reset = 1'b1;
      for (i = 0; i < NUM_MEMBERS; i++) begin
         mbr_known[i] = 1'b0;
         mbr_group[i] = '0;
         mbr_slot[i] = '0;
      end
      for (i = 0; i < NUM_GROUPS; i++) begin
         slot_used[i] = '0;
         written_depth[i] = 0;
         for (j = 0; j < GROUP_SLOTS; j++) slot_owner[i][j] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_add_lookup();
      test_readd();
      test_remove_corners();
      test_gap_shift();
      test_full_group();
      test_backpressure();
      test_random_ops();

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/gmt_pkg.sv
rtl/gmt_if.sv
rtl/gmt_ram.sv
rtl/gmt_ctrl.sv
rtl/group_membership_table.sv
rtl/gmt_checker.sv
dv/group_membership_table_tb.sv
